### rtl/core/kvm_pkg.sv
// ----------------------------------------------------------------------------
// kvm_pkg
// Shared types, constants and command codes of the keyframe vertex morph
// animator: payload structs, configuration and control bundles.
// ----------------------------------------------------------------------------
package kvm_pkg;

  localparam int FRAME_W     = 6;
  localparam int VERT_W      = 10;
  localparam int ADDR_W      = FRAME_W + VERT_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int COORD_W     = 32;
  localparam int PHASE_W     = 17;
  localparam int SPEED_W     = 16;
  localparam int DT_W        = 16;
  localparam int FCOUNT_W    = 7;
  localparam int VCOUNT_W    = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_LANES   = 3;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FCOUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT  = 3'd5;

  typedef struct packed {
    logic [1:0]                command;
    logic [FRAME_W-1:0]        frame_index;
    logic [VERT_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [DT_W-1:0]           delta_time;
    logic [FRAME_W-1:0]        range_start;
    logic [FRAME_W-1:0]        range_end;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]        frame_now;
    logic [PHASE_W-1:0]        blend_phase;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } out_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  anim_speed;
    logic                interpolate_mode;
    logic                connected_loop;
    logic                update_enable;
    logic [FCOUNT_W-1:0] frame_count;
    logic [VCOUNT_W-1:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic               play;
    logic               tick_mul;
    logic               tick_upd;
    logic [FRAME_W-1:0] range_start;
    logic [FRAME_W-1:0] range_end;
    logic [DT_W-1:0]    delta_time;
  } anim_ctrl_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_now;
    logic [PHASE_W-1:0] phase;
    logic [FRAME_W-1:0] shown_from;
    logic [FRAME_W-1:0] shown_to;
    logic [PHASE_W-1:0] shown_weight;
  } anim_state_t;

  typedef struct packed {
    logic capture_a;
    logic capture_prod;
  } blend_ctrl_t;

  typedef logic [NUM_LANES-1:0][COORD_W-1:0] lanes_t;

endpackage

### rtl/core/kvm_ram.sv
// ----------------------------------------------------------------------------
// kvm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kvm_anim.sv
// ----------------------------------------------------------------------------
// kvm_anim
// Animation state: phase accumulation, frame stepping over the play range
// and the displayed frame pair with its blend weight.
// ----------------------------------------------------------------------------
module kvm_anim (
  input  logic                clk,
  input  logic                rst_n,
  input  kvm_pkg::cfg_t       cfg,
  input  kvm_pkg::anim_ctrl_t ctrl,
  output kvm_pkg::anim_state_t st
);
  import kvm_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [FRAME_W-1:0] first_r, first_nxt;
  logic [FRAME_W-1:0] last_r, last_nxt;
  logic [FRAME_W-1:0] from_r, from_nxt;
  logic [FRAME_W-1:0] to_r, to_nxt;
  logic [PHASE_W-1:0] weight_r, weight_nxt;
  logic [SPEED_W+DT_W-1:0] prod_r;

  logic               tick_live;
  logic [24:0]        phase_sum;
  logic [PHASE_W-1:0] phase_sat;
  logic [FRAME_W:0]   limit;
  logic [FRAME_W:0]   step;
  logic               wrap;
  logic [FRAME_W-1:0] next_shown;
  logic [FRAME_W-1:0] cur_adv;

  // speed times delta, registered ahead of the phase add
  always_ff @(posedge clk) begin
    if (ctrl.tick_mul) begin
      prod_r <= cfg.anim_speed * ctrl.delta_time;
    end
  end

  always_comb begin
    tick_live  = (cfg.frame_count > 7'd1) && cfg.update_enable;
    phase_sum  = {8'b0, phase_r} + {1'b0, prod_r[SPEED_W+DT_W-1:8]};
    phase_sat  = (phase_sum >= {8'b0, PHASE_ONE}) ? PHASE_ONE : phase_sum[PHASE_W-1:0];
    limit      = {1'b0, last_r} + {{FRAME_W{1'b0}}, cfg.connected_loop};
    next_shown = (cfg.connected_loop && (cur_r == last_r)) ? first_r
                                                           : cur_r + 6'd1;
    step       = {1'b0, cur_r} + 7'd1;
    wrap       = cfg.connected_loop ? (step > {1'b0, last_r}) : (step >= {1'b0, last_r});
    cur_adv    = wrap ? first_r : step[FRAME_W-1:0];

    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    from_nxt   = from_r;
    to_nxt     = to_r;
    weight_nxt = weight_r;

    priority if (ctrl.play) begin
      first_nxt = ctrl.range_start;
      last_nxt  = ctrl.range_end;
      cur_nxt   = ctrl.range_start;
      phase_nxt = '0;
    end else if (ctrl.tick_upd && tick_live) begin
      phase_nxt = phase_sat;
      if (cfg.interpolate_mode && ({1'b0, cur_r} < limit)) begin
        from_nxt   = cur_r;
        to_nxt     = next_shown;
        weight_nxt = phase_sat;
      end
      // advance the frame once the phase is full
      if (phase_sat == PHASE_ONE) begin
        phase_nxt = '0;
        cur_nxt   = cur_adv;
        if (!cfg.interpolate_mode) begin
          from_nxt   = cur_adv;
          to_nxt     = cur_adv;
          weight_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      cur_r    <= '0;
      first_r  <= '0;
      last_r   <= '0;
      from_r   <= '0;
      to_r     <= '0;
      weight_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      from_r   <= from_nxt;
      to_r     <= to_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign st.frame_now    = cur_r;
  assign st.phase        = phase_r;
  assign st.shown_from   = from_r;
  assign st.shown_to     = to_r;
  assign st.shown_weight = weight_r;

endmodule

### rtl/core/kvm_blend.sv
// ----------------------------------------------------------------------------
// kvm_blend
// Three-lane blend datapath: a + floor((b - a) * w / 65536) per coordinate,
// with the frame-a sample and the product held in registers.
// ----------------------------------------------------------------------------
module kvm_blend (
  input  logic                         clk,
  input  kvm_pkg::blend_ctrl_t         ctrl,
  input  kvm_pkg::lanes_t              rdata,
  input  logic [kvm_pkg::PHASE_W-1:0]  weight,
  output kvm_pkg::lanes_t              result
);
  import kvm_pkg::*;

  localparam int PROD_W = COORD_W + 1 + PHASE_W + 1;

  logic [NUM_LANES-1:0][COORD_W-1:0] a_r;
  logic signed [PROD_W-1:0]          prod_r [NUM_LANES];

  logic signed [COORD_W:0]           diff   [NUM_LANES];
  logic signed [PROD_W-17:0]         term   [NUM_LANES];
  logic signed [PROD_W-17:0]         sum    [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      diff[i] = $signed({rdata[i][COORD_W-1], rdata[i]})
              - $signed({a_r[i][COORD_W-1], a_r[i]});
      // dropping the low bits of the signed product gives the floor
      term[i] = prod_r[i][PROD_W-1:16];
      sum[i]  = $signed({{(PROD_W-16-COORD_W){a_r[i][COORD_W-1]}}, a_r[i]}) + term[i];
      result[i] = sum[i][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (ctrl.capture_a) begin
        a_r[i] <= rdata[i];
      end
      if (ctrl.capture_prod) begin
        prod_r[i] <= diff[i] * $signed({1'b0, weight});
      end
    end
  end

endmodule

### rtl/core/keyframe_vertex_morph_animator_core.sv
// ----------------------------------------------------------------------------
// keyframe_vertex_morph_animator_core
// Each command runs to completion before the next is taken (in_stall is high
// outside the idle state). A read fetches frame a then frame b through the
// single read port of the frame store RAM.
// A result may wait in the output register while the next command runs.
// Reset restores the configuration defaults and clears animation state and
// handshakes; the frame store holds undefined data until loaded.
// ----------------------------------------------------------------------------
module keyframe_vertex_morph_animator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kvm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kvm_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kvm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_RDM  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  in_item_t    item_r;
  cfg_t        cfg_r, cfg_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  anim_ctrl_t  anim_ctrl;
  anim_state_t anim_st;
  blend_ctrl_t blend_ctrl;
  lanes_t      wdata;
  lanes_t      rdata;
  lanes_t      blended;

  logic              in_xfer;
  logic              slot_free;
  logic              store_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              rd_in_range;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPEED:   cfg_nxt.anim_speed       = cfg_data[SPEED_W-1:0];
        REG_INTERP:  cfg_nxt.interpolate_mode = cfg_data[0];
        REG_CONNECT: cfg_nxt.connected_loop   = cfg_data[0];
        REG_UPDATE:  cfg_nxt.update_enable    = cfg_data[0];
        REG_FCOUNT:  cfg_nxt.frame_count      = cfg_data[FCOUNT_W-1:0];
        REG_VCOUNT:  cfg_nxt.vertex_count     = cfg_data[VCOUNT_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (item_r.command)
          CMD_TICK: state_nxt = S_TICK;
          CMD_READ: state_nxt = S_RDB;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_TICK:  state_nxt = S_FIN;
      S_RDB:   state_nxt = S_RDM;
      S_RDM:   state_nxt = S_FIN;
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    anim_ctrl.play        = (state_r == S_EXEC) && (item_r.command == CMD_PLAY);
    anim_ctrl.tick_mul    = (state_r == S_EXEC) && (item_r.command == CMD_TICK);
    anim_ctrl.tick_upd    = (state_r == S_TICK);
    anim_ctrl.range_start = item_r.range_start;
    anim_ctrl.range_end   = item_r.range_end;
    anim_ctrl.delta_time  = item_r.delta_time;

    blend_ctrl.capture_a    = (state_r == S_RDB);
    blend_ctrl.capture_prod = (state_r == S_RDM);

    store_we = (state_r == S_EXEC) && (item_r.command == CMD_LOAD);
    waddr    = {item_r.frame_index, item_r.vertex_index};
    // fetch frame a in the execute state and frame b in the cycle after it
    raddr    = (state_r == S_EXEC) ? {anim_st.shown_from, item_r.vertex_index}
                                   : {anim_st.shown_to, item_r.vertex_index};
    wdata[0] = item_r.coord_x;
    wdata[1] = item_r.coord_y;
    wdata[2] = item_r.coord_z;

    rd_in_range = (item_r.command == CMD_READ) &&
                  ({1'b0, item_r.vertex_index} < cfg_r.vertex_count);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_FIN) && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= S_IDLE;
      out_valid_r            <= 1'b0;
      cfg_r.anim_speed       <= 16'd256;
      cfg_r.interpolate_mode <= 1'b0;
      cfg_r.connected_loop   <= 1'b0;
      cfg_r.update_enable    <= 1'b1;
      cfg_r.frame_count      <= 7'd1;
      cfg_r.vertex_count     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if ((state_r == S_FIN) && slot_free) begin
      out_data_r.frame_now   <= anim_st.frame_now;
      out_data_r.blend_phase <= anim_st.phase;
      out_data_r.out_x       <= rd_in_range ? blended[0] : '0;
      out_data_r.out_y       <= rd_in_range ? blended[1] : '0;
      out_data_r.out_z       <= rd_in_range ? blended[2] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one entry holds all three coordinates of a vertex
  kvm_ram #(
    .WIDTH (NUM_LANES * COORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  kvm_anim u_anim (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .ctrl  (anim_ctrl),
    .st    (anim_st)
  );

  kvm_blend u_blend (
    .clk    (clk),
    .ctrl   (blend_ctrl),
    .rdata  (rdata),
    .weight (anim_st.shown_weight),
    .result (blended)
  );

endmodule

### verif/keyframe_vertex_morph_animator_core_test.sv
// ----------------------------------------------------------------------------
// keyframe_vertex_morph_animator_core_test
// Self-checking bench for the morph animator core. Every command is run
// through a local model of the frame store, animation state and blend
// arithmetic. The expected result is queued and compared field by field
// with each transfer out of the block. Directed cases cover coordinate
// extremes, saturation, reversed and connected ranges, frozen animation
// and reads past the vertex count. Random traffic then follows under
// changing settings, idle patterns and a long output hold.
// ----------------------------------------------------------------------------
module keyframe_vertex_morph_animator_core_test;
  import kvm_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 80;
  localparam int NUM_FRAMES   = 1 << FRAME_W;
  localparam int HOT_VERTS    = 4;
  localparam int PRINT_LIMIT  = 60;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  keyframe_vertex_morph_animator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Model of the animator: settings, frame store and animation state
  cfg_t                 regs = {16'd256, 1'b0, 1'b0, 1'b1, 7'd1, 11'd0};
  logic [COORD_W-1:0]   pos_x [int unsigned];
  logic [COORD_W-1:0]   pos_y [int unsigned];
  logic [COORD_W-1:0]   pos_z [int unsigned];
  logic [PHASE_W-1:0]   m_phase = '0;
  logic [FRAME_W-1:0]   m_cur = '0;
  logic [FRAME_W-1:0]   m_first = '0;
  logic [FRAME_W-1:0]   m_last = '0;
  logic [FRAME_W-1:0]   m_from = '0;
  logic [FRAME_W-1:0]   m_to = '0;
  logic [PHASE_W-1:0]   m_weight = '0;

  out_item_t    expected_poses [$];
  int           error_count = 0;
  int           results_seen = 0;
  int           n_loads = 0;
  int           n_ticks = 0;
  int           n_plays = 0;
  int           n_reads = 0;
  int           n_advances = 0;
  int unsigned  cycle_count = 0;

  int           send_gap_pct = 25;
  int           recv_stall_pct = 69;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  // a + floor((b - a) * w / 2^16), wrapped to the coordinate width
  function automatic logic [COORD_W-1:0] mix_coord(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [PHASE_W-1:0] w);
    longint da;
    longint db;
    longint term;
    logic [63:0] sum;
    da = longint'($signed(a));
    db = longint'($signed(b));
    term = ((db - da) * longint'(w)) >>> 16;
    sum = da + term;
    return sum[COORD_W-1:0];
  endfunction

  task automatic morph_predict(input in_item_t it, output out_item_t res);
    longint unsigned gain;
    int unsigned p;
    int unsigned c;
    int unsigned lim;
    int unsigned ka;
    int unsigned kb;
    res = '0;
    case (it.command)
      CMD_LOAD: begin
        n_loads++;
        ka = {it.frame_index, it.vertex_index};
        pos_x[ka] = it.coord_x;
        pos_y[ka] = it.coord_y;
        pos_z[ka] = it.coord_z;
      end
      CMD_TICK: begin
        n_ticks++;
        if (regs.frame_count > 1 && regs.update_enable) begin
          gain = regs.anim_speed;
          gain = gain * it.delta_time;
          p = m_phase + (gain >> 8);
          if (p > PHASE_ONE) p = PHASE_ONE;
          m_phase = p[PHASE_W-1:0];
          if (regs.interpolate_mode) begin
            lim = m_last + regs.connected_loop;
            if (m_cur < lim) begin
              m_to = (regs.connected_loop && m_cur == m_last) ? m_first : m_cur + 1'b1;
              m_from = m_cur;
              m_weight = m_phase;
            end
          end
          if (m_phase == PHASE_ONE) begin
            n_advances++;
            c = m_cur + 1;
            m_phase = '0;
            if (regs.connected_loop ? (c > m_last) : (c >= m_last)) c = m_first;
            m_cur = c[FRAME_W-1:0];
            if (!regs.interpolate_mode) begin
              m_from = m_cur;
              m_to = m_cur;
              m_weight = '0;
            end
          end
        end
      end
      CMD_PLAY: begin
        n_plays++;
        m_first = it.range_start;
        m_cur = it.range_start;
        m_last = it.range_end;
        m_phase = '0;
      end
      default: begin
        n_reads++;
        if (it.vertex_index < regs.vertex_count) begin
          ka = {m_from, it.vertex_index};
          kb = {m_to, it.vertex_index};
          res.out_x = mix_coord(pos_x[ka], pos_x[kb], m_weight);
          res.out_y = mix_coord(pos_y[ka], pos_y[kb], m_weight);
          res.out_z = mix_coord(pos_z[ka], pos_z[kb], m_weight);
        end
      end
    endcase
    res.frame_now = m_cur;
    res.blend_phase = m_phase;
  endtask

  // A read is allowed only where it leaves the store alone or hits written entries
  function automatic bit read_safe(input logic [VERT_W-1:0] v);
    return v >= regs.vertex_count ||
           (pos_x.exists({m_from, v}) && pos_x.exists({m_to, v}));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random content in every field but the command; the caller sets what the command uses
  function automatic in_item_t noise_item(input logic [1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.frame_index = FRAME_W'($urandom);
    it.vertex_index = VERT_W'($urandom);
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    it.delta_time = DT_W'($urandom);
    it.range_start = FRAME_W'($urandom);
    it.range_end = FRAME_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    logic [VERT_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 12) begin
      it = noise_item(CMD_LOAD);
      if ($urandom_range(9) < 7) it.vertex_index = VERT_W'($urandom_range(7));
      it.coord_x = pick_coord();
      it.coord_y = pick_coord();
      it.coord_z = pick_coord();
    end else if (pick < 57) begin
      it = noise_item(CMD_TICK);
      case ($urandom_range(4))
        0, 1: it.delta_time = DT_W'($urandom_range(16'h1800));
        2, 3: ;
        default: it.delta_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
    end else if (pick < 65) begin
      it = noise_item(CMD_PLAY);
      // mostly short forward spans; the rest may come out reversed
      if ($urandom_range(4) != 0)
        it.range_end = it.range_start + FRAME_W'($urandom_range(5, 1));
    end else begin
      it = noise_item(CMD_READ);
      case ($urandom_range(19))
        0, 1, 2:    v = VERT_W'($urandom);
        3, 4, 5, 6: v = VERT_W'($urandom_range(15));
        default:    v = VERT_W'($urandom_range(HOT_VERTS - 1));
      endcase
      if (!read_safe(v)) v = VERT_W'($urandom_range(HOT_VERTS - 1));
      it.vertex_index = v;
    end
    return it;
  endfunction

  // Predict, then offer the item until the block takes it
  task automatic push_item(input in_item_t it);
    out_item_t want;
    morph_predict(it, want);
    expected_poses.push_back(want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(input logic [FRAME_W-1:0] f, input logic [VERT_W-1:0] v,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z);
    in_item_t it;
    it = noise_item(CMD_LOAD);
    it.frame_index = f;
    it.vertex_index = v;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    push_item(it);
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt);
    in_item_t it;
    it = noise_item(CMD_TICK);
    it.delta_time = dt;
    push_item(it);
  endtask

  task automatic send_play(input logic [FRAME_W-1:0] s, input logic [FRAME_W-1:0] e);
    in_item_t it;
    it = noise_item(CMD_PLAY);
    it.range_start = s;
    it.range_end = e;
    push_item(it);
  endtask

  task automatic send_read(input logic [VERT_W-1:0] v);
    in_item_t it;
    it = noise_item(CMD_READ);
    it.vertex_index = v;
    push_item(it);
  endtask

  // Drop valid and drain every outstanding result, plus the pipeline tail
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    logic [CFG_IDX_W-1:0] idx;
    wait_idle();
    regs = s;
    for (int k = REG_SPEED; k <= REG_VCOUNT; k++) begin
      idx = CFG_IDX_W'(k);
      case (idx)
        REG_SPEED:   cfg_data <= s.anim_speed;
        REG_INTERP:  cfg_data <= CFG_DATA_W'(s.interpolate_mode);
        REG_CONNECT: cfg_data <= CFG_DATA_W'(s.connected_loop);
        REG_UPDATE:  cfg_data <= CFG_DATA_W'(s.update_enable);
        REG_FCOUNT:  cfg_data <= CFG_DATA_W'(s.frame_count);
        default:     cfg_data <= CFG_DATA_W'(s.vertex_count);
      endcase
      cfg_index <= idx;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_blend_extremes();
    apply_setting({16'd256, 1'b1, 1'b0, 1'b1, 7'd64, 11'd1024});
    send_load(6'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_load(6'd1, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_play(6'd0, 6'd1);
    send_tick(16'h8000);
    send_read(10'd0);
    // saturate the phase: full weight on frame 1, then wrap to the start
    send_tick(16'hFFFF);
    send_read(10'd0);
  endtask

  task automatic test_abrupt_switch();
    apply_setting({16'd65535, 1'b0, 1'b0, 1'b1, 7'd64, 11'd1024});
    send_play(6'd0, 6'd2);
    send_tick(16'h0001);
    send_tick(16'hFFFF);
    send_read(10'd0);
    send_tick(16'hFFFF);
  endtask

  task automatic test_reversed_range();
    apply_setting({16'd256, 1'b1, 1'b0, 1'b1, 7'd64, 11'd1024});
    send_play(6'd63, 6'd0);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_read(10'd0);
  endtask

  task automatic test_connected_loop();
    apply_setting({16'd256, 1'b1, 1'b1, 1'b1, 7'd64, 11'd1024});
    send_load(6'd62, 10'd0, pick_coord(), pick_coord(), pick_coord());
    send_load(6'd63, 10'd0, pick_coord(), pick_coord(), pick_coord());
    send_play(6'd62, 6'd63);
    send_tick(16'hFFFF);
    send_tick(16'h0001);
    // at the end frame the blend heads back to the start frame
    send_tick(16'h4000);
    send_read(10'd0);
  endtask

  task automatic test_frozen_animation();
    apply_setting({16'd256, 1'b1, 1'b0, 1'b1, 7'd1, 11'd1024});
    send_tick(16'hFFFF);
    apply_setting({16'd256, 1'b1, 1'b0, 1'b0, 7'd64, 11'd0});
    send_tick(16'hFFFF);
    send_read(10'd1023);
    apply_setting({16'd256, 1'b1, 1'b0, 1'b1, 7'd0, 11'd2047});
    send_tick(16'hFFFF);
  endtask

  task automatic test_random_mix();
    cfg_t s;
    apply_setting({16'd256, 1'b1, 1'b0, 1'b1, 7'd64, 11'd16});
    for (int f = 0; f < NUM_FRAMES; f++)
      for (int v = 0; v < HOT_VERTS; v++)
        send_load(FRAME_W'(f), VERT_W'(v), pick_coord(), pick_coord(), pick_coord());
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 8)
        0: s = {16'd256,   1'b1, 1'b0, 1'b1, 7'd64,  11'd16};
        1: s = {16'd65535, 1'b1, 1'b1, 1'b1, 7'd64,  11'd16};
        2: s = {16'd0,     1'b1, 1'b0, 1'b1, 7'd64,  11'd16};
        3: s = {16'd1024,  1'b0, 1'b0, 1'b1, 7'd64,  11'd8};
        4: s = {16'd512,   1'b1, 1'b1, 1'b1, 7'd2,   11'd16};
        5: s = {16'd300,   1'b0, 1'b1, 1'b1, 7'd127, 11'd1024};
        6: s = {16'd256,   1'b1, 1'b0, 1'b0, 7'd64,  11'd16};
        default: s = {16'd2048, 1'b1, 1'b1, 1'b1, 7'd0, 11'd2047};
      endcase
      apply_setting(s);
      case (seg / 4)
        0: begin send_gap_pct = 25; recv_stall_pct = 69; end
        1: begin send_gap_pct = 69; recv_stall_pct = 25; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (SEG_ITEMS) push_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    apply_setting({16'd256, 1'b1, 1'b1, 1'b1, 7'd64, 11'd16});
    send_gap_pct = 0;
    recv_stall_pct = 0;
    // hold the output long enough that the block backs up into its input
    hold_requests++;
    repeat (40) push_item(random_item());
  endtask

  // Receiver: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_poses.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_poses.pop_front();
        if (out_data.frame_now !== want.frame_now)
          flag_error($sformatf("result %0d frame_now %0d, expected %0d",
                               results_seen, out_data.frame_now, want.frame_now));
        if (out_data.blend_phase !== want.blend_phase)
          flag_error($sformatf("result %0d blend_phase %h, expected %h",
                               results_seen, out_data.blend_phase, want.blend_phase));
        if (out_data.out_x !== want.out_x)
          flag_error($sformatf("result %0d out_x %h, expected %h",
                               results_seen, out_data.out_x, want.out_x));
        if (out_data.out_y !== want.out_y)
          flag_error($sformatf("result %0d out_y %h, expected %h",
                               results_seen, out_data.out_y, want.out_y));
        if (out_data.out_z !== want.out_z)
          flag_error($sformatf("result %0d out_z %h, expected %h",
                               results_seen, out_data.out_z, want.out_z));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_poses.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_blend_extremes();
    test_abrupt_switch();
    test_reversed_range();
    test_connected_loop();
    test_frozen_animation();
    test_random_mix();
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d loads, %0d ticks, %0d plays, %0d reads, %0d advances.",
             results_seen, n_loads, n_ticks, n_plays, n_reads, n_advances);
    $display("Swept speed and count extremes, blend and loop modes, frozen playback, stalls.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### keyframe_vertex_morph_animator_core.f
rtl/core/kvm_pkg.sv
rtl/core/kvm_ram.sv
rtl/core/kvm_anim.sv
rtl/core/kvm_blend.sv
rtl/core/keyframe_vertex_morph_animator_core.sv
verif/keyframe_vertex_morph_animator_core_test.sv
